// ===== rtl/pad_pkg.sv =====
// Shared types, constants and helpers for the page access decay tracker.
// Used by the front, back, top level and checker; depends on nothing else.

package pad_pkg;

	localparam int PAGE_SLOTS_DEF     = 1024;
	localparam int FILE_SLOTS_DEF     = 256;
	localparam int MAX_HALF_LIVES_DEF = 10;

	localparam logic [39:0] HALF_LIFE_RESET = 40'd1000000000;
	localparam logic [63:0] GAP_UNKNOWN     = 64'hffff_ffff_ffff_ffff;
	localparam logic [31:0] DIST_UNKNOWN    = 32'hffff_ffff;
	localparam logic [31:0] SCORE_STEP      = 32'd1000;
	localparam logic [9:0]  FACTOR_ONE      = 10'd1000;

	// ceil(2^46 / 125): exact floor division by 125 for operands below 2^39.
	localparam logic [39:0] RECIP_125       = 40'd562949953422;

	typedef enum logic [1:0] {
		OP_ACCESS = 2'd0,
		OP_INSERT = 2'd1,
		OP_EVICT  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic KIND_ACCESS = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	// One event after filtering, with slots already reduced to table range.
	typedef struct packed {
		op_t         op;
		logic [9:0]  page_slot;
		logic [7:0]  file_slot;
		logic [31:0] device_id;
		logic [63:0] inode;
		logic [63:0] index;
		logic [63:0] now;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] page_gap;
		logic [63:0] page_gap_two;
		logic [63:0] file_gap;
		logic [63:0] file_gap_two;
		logic [11:0] major;
		logic [19:0] minor;
		logic [63:0] inode;
		logic [63:0] index;
		logic [31:0] seq;
		logic [31:0] page_score;
		logic [31:0] file_score;
	} result_t;

	// The known flag stands for "last gap is not all ones".
	typedef struct packed {
		logic        valid;
		logic        known;
		logic [63:0] prev_time;
		logic [63:0] last_time;
		logic [31:0] freq;
	} page_ent_t;

	typedef struct packed {
		logic        valid;
		logic        known;
		logic [63:0] recent_index;
		logic [63:0] prev_time;
		logic [63:0] last_time;
		logic [31:0] hot;
	} file_ent_t;

	// Restoring remainder of a narrow slot number by the table size.
	function automatic logic [9:0] slot_mod(logic [9:0] value, int unsigned slots);
		logic [16:0] rem;
		rem = '0;
		for (int i = 9; i >= 0; i--) begin
			rem = {rem[15:0], value[i]};
			if (rem >= 17'(slots))
				rem = rem - 17'(slots);
		end
		return rem[9:0];
	endfunction

endpackage

// ===== rtl/pad_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.

module pad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/pad_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on nothing.

module pad_div #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic         run_q;
	logic         done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W:0]   rem_q;
	logic [W-1:0] den_q;
	logic [W:0]   rem_sh;
	logic         ge;

	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign ge       = rem_sh >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
				quo_q <= dividend;
				rem_q <= '0;
				den_q <= divisor;
			end else if (run_q) begin
				rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pad_front.sv =====
// Front end: takes events, drops ignored ones, reduces slots and queues the rest.
// Depends on pad_pkg.

module pad_front #(
	parameter int PAGE_SLOTS = pad_pkg::PAGE_SLOTS_DEF,
	parameter int FILE_SLOTS = pad_pkg::FILE_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          hold,
	input  logic [1:0]    operation,
	input  logic [9:0]    page_slot,
	input  logic [7:0]    file_slot,
	input  logic [31:0]   device_id,
	input  logic [63:0]   inode_number,
	input  logic [63:0]   page_index,
	input  logic [63:0]   time_now,
	input  logic          pop,
	output logic          busy,
	output logic          head_valid,
	output pad_pkg::cmd_t head
);

	localparam int QD = 2;

	pad_pkg::cmd_t q_mem_q [QD];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;
	pad_pkg::cmd_t cmd;

	assign busy       = hold || (cnt_q == 2'(QD));
	assign head_valid = cnt_q != 2'd0;
	assign head       = q_mem_q[rd_ptr_q];
	assign push       = start && !busy && device_id != 32'd0 && inode_number != 64'd0
		&& pad_pkg::op_t'(operation) != pad_pkg::OP_NONE;

	always_comb begin
		cmd.op        = pad_pkg::op_t'(operation);
		cmd.page_slot = pad_pkg::slot_mod(page_slot, PAGE_SLOTS);
		cmd.file_slot = 8'(pad_pkg::slot_mod({2'b00, file_slot}, FILE_SLOTS));
		cmd.device_id = device_id;
		cmd.inode     = inode_number;
		cmd.index     = page_index;
		cmd.now       = time_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				q_mem_q[wr_ptr_q] <= cmd;
				wr_ptr_q          <= !wr_ptr_q;
			end
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/pad_back.sv =====
// Back end: table memories, clearing pass, gap and score sequencer, result register.
// Depends on pad_pkg, pad_ram and pad_div.

module pad_back #(
	parameter int PAGE_SLOTS     = pad_pkg::PAGE_SLOTS_DEF,
	parameter int FILE_SLOTS     = pad_pkg::FILE_SLOTS_DEF,
	parameter int MAX_HALF_LIVES = pad_pkg::MAX_HALF_LIVES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [39:0]      half_life,
	input  logic             head_valid,
	input  pad_pkg::cmd_t    head,
	output logic             pop,
	output logic             clearing,
	output logic             result_valid,
	output pad_pkg::result_t result
);

	localparam int PW    = $clog2(PAGE_SLOTS);
	localparam int FW    = $clog2(FILE_SLOTS);
	localparam int CLR_N = (PAGE_SLOTS > FILE_SLOTS) ? PAGE_SLOTS : FILE_SLOTS;
	localparam int CW    = $clog2(CLR_N);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_PAGE_CHK, ST_FILE_CHK,
		ST_DSTART, ST_DIV1, ST_MUL, ST_RCP_LO, ST_RCP_HI, ST_WRITE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      clr_q;
	pad_pkg::cmd_t      cmd_q;
	pad_pkg::page_ent_t pe_q;
	pad_pkg::file_ent_t fe_q;
	logic [63:0]        pg_q, pg2_q, fg_q, fg2_q;
	logic [31:0]        seq_q, freq_q, hot_q;
	logic               sel_q, small_q;
	logic [9:0]         factor_q;
	logic [41:0]        prod_q;
	logic [58:0]        part_lo_q;
	logic               result_valid_q;
	pad_pkg::result_t   result_q;

	pad_pkg::page_ent_t page_rd, page_wr;
	pad_pkg::file_ent_t file_rd, file_wr;
	logic               page_we, file_we;
	logic [PW-1:0]      page_waddr, page_raddr;
	logic [FW-1:0]      file_waddr, file_raddr;
	logic               clr_page, clr_file;

	logic [39:0]        hl;
	logic [63:0]        pg, pg2, fg, fg2, diff, gap, old_ext;
	logic [31:0]        old;
	logic               div_start, div_done;
	logic [63:0]        div_dividend, div_divisor, div_quot;
	logic [38:0]        rcp_in;
	logic [58:0]        part_lo, part_hi;
	logic [78:0]        rcp_sum;
	logic [31:0]        score_new;
	pad_pkg::result_t   result_d;

	function automatic logic [63:0] gap_from(logic [63:0] now, logic [63:0] then);
		return (now >= then) ? now - then : pad_pkg::GAP_UNKNOWN;
	endfunction

	assign hl        = (half_life == 40'd0) ? 40'd1 : half_life;
	assign clearing  = state_q == ST_CLEAR;
	assign pop       = state_q == ST_IDLE && head_valid;
	assign clr_page  = {1'b0, clr_q} < (CW + 1)'(PAGE_SLOTS);
	assign clr_file  = {1'b0, clr_q} < (CW + 1)'(FILE_SLOTS);
	assign page_raddr = PW'(head.page_slot);
	assign file_raddr = FW'(head.file_slot);
	assign page_waddr = clearing ? PW'(clr_q) : PW'(cmd_q.page_slot);
	assign file_waddr = clearing ? FW'(clr_q) : FW'(cmd_q.file_slot);
	assign page_we   = (clearing && clr_page) || state_q == ST_WRITE;
	assign file_we   = (clearing && clr_file)
		|| (state_q == ST_WRITE && cmd_q.op != pad_pkg::OP_EVICT);

	// Gaps and sequential distance from the freshly read entries.
	always_comb begin
		pg   = pe_q.valid ? gap_from(cmd_q.now, pe_q.last_time) : pad_pkg::GAP_UNKNOWN;
		pg2  = (pe_q.valid && pe_q.prev_time != 64'd0)
			? gap_from(cmd_q.now, pe_q.prev_time) : pad_pkg::GAP_UNKNOWN;
		fg   = fe_q.valid ? gap_from(cmd_q.now, fe_q.last_time) : pad_pkg::GAP_UNKNOWN;
		fg2  = (fe_q.valid && fe_q.prev_time != 64'd0)
			? gap_from(cmd_q.now, fe_q.prev_time) : pad_pkg::GAP_UNKNOWN;
		diff = (cmd_q.index > fe_q.recent_index) ? cmd_q.index - fe_q.recent_index
			: fe_q.recent_index - cmd_q.index;
	end

	assign gap     = sel_q ? fg_q : pg_q;
	assign old     = sel_q ? hot_q : freq_q;
	assign old_ext = 64'(gap[39:0]) * 64'(pad_pkg::FACTOR_ONE);

	assign div_start    = state_q == ST_DSTART;
	assign div_dividend = (gap < {24'd0, hl}) ? old_ext : gap;
	assign div_divisor  = {24'd0, hl};

	// Divide by 1000 as a divide by 8 and a reciprocal multiply for 125, in two halves.
	assign rcp_in    = prod_q[41:3];
	assign part_lo   = 59'(rcp_in) * 59'(pad_pkg::RECIP_125[19:0]);
	assign part_hi   = 59'(rcp_in) * 59'(pad_pkg::RECIP_125[39:20]);
	assign rcp_sum   = {20'd0, part_lo_q} + {part_hi, 20'd0};
	assign score_new = rcp_sum[77:46] + pad_pkg::SCORE_STEP;

	always_comb begin
		page_wr = '0;
		file_wr = '0;
		if (!clearing && cmd_q.op != pad_pkg::OP_EVICT) begin
			page_wr.valid     = 1'b1;
			page_wr.prev_time = pe_q.valid ? pe_q.last_time : 64'd0;
			page_wr.last_time = cmd_q.now;
			file_wr.valid        = 1'b1;
			file_wr.prev_time    = fe_q.valid ? fe_q.last_time : 64'd0;
			file_wr.last_time    = cmd_q.now;
			file_wr.recent_index = cmd_q.index;
			if (cmd_q.op == pad_pkg::OP_ACCESS) begin
				page_wr.known = pe_q.valid && pg_q != pad_pkg::GAP_UNKNOWN;
				page_wr.freq  = freq_q;
				file_wr.known = fe_q.valid && fg_q != pad_pkg::GAP_UNKNOWN;
				file_wr.hot   = hot_q;
			end else begin
				page_wr.known = pe_q.valid && pe_q.known;
				page_wr.freq  = pe_q.valid ? pe_q.freq : 32'd0;
				file_wr.known = fe_q.valid && fe_q.known;
				file_wr.hot   = fe_q.valid ? fe_q.hot : 32'd0;
			end
		end
	end

	always_comb begin
		result_d       = '0;
		result_d.major = cmd_q.device_id[31:20];
		result_d.minor = cmd_q.device_id[19:0];
		result_d.inode = cmd_q.inode;
		result_d.index = cmd_q.index;
		if (cmd_q.op == pad_pkg::OP_ACCESS) begin
			result_d.kind         = pad_pkg::KIND_ACCESS;
			result_d.page_gap     = pg_q;
			result_d.page_gap_two = pg2_q;
			result_d.file_gap     = fg_q;
			result_d.file_gap_two = fg2_q;
			result_d.seq          = seq_q;
			result_d.page_score   = freq_q;
			result_d.file_score   = hot_q;
		end else begin
			result_d.kind = pad_pkg::KIND_INSERT;
		end
	end

	pad_ram #(.WIDTH($bits(pad_pkg::page_ent_t)), .DEPTH(PAGE_SLOTS)) u_page_ram (
		.clk   (clk),
		.we    (page_we),
		.waddr (page_waddr),
		.wdata (page_wr),
		.raddr (page_raddr),
		.rdata (page_rd)
	);

	pad_ram #(.WIDTH($bits(pad_pkg::file_ent_t)), .DEPTH(FILE_SLOTS)) u_file_ram (
		.clk   (clk),
		.we    (file_we),
		.waddr (file_waddr),
		.wdata (file_wr),
		.raddr (file_raddr),
		.rdata (file_rd)
	);

	pad_div #(.W(64)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == ST_WRITE) && (cmd_q.op != pad_pkg::OP_EVICT);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (head_valid) begin
						cmd_q   <= head;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					pe_q    <= page_rd;
					fe_q    <= file_rd;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					pg_q  <= pg;
					pg2_q <= pg2;
					fg_q  <= fg;
					fg2_q <= fg2;
					seq_q <= !fe_q.valid ? pad_pkg::DIST_UNKNOWN
						: (diff > 64'(pad_pkg::DIST_UNKNOWN)) ? pad_pkg::DIST_UNKNOWN
						: diff[31:0];
					// Scores start from the cases that need no decay.
					if (!(pe_q.valid && pe_q.known))
						freq_q <= pad_pkg::SCORE_STEP;
					else if (pg == 64'd0)
						freq_q <= pe_q.freq + pad_pkg::SCORE_STEP;
					else
						freq_q <= pe_q.freq;
					if (!fe_q.valid)
						hot_q <= pad_pkg::SCORE_STEP;
					else if (fe_q.known && fg == 64'd0)
						hot_q <= fe_q.hot + pad_pkg::SCORE_STEP;
					else
						hot_q <= fe_q.hot;
					state_q <= (cmd_q.op == pad_pkg::OP_ACCESS) ? ST_PAGE_CHK : ST_WRITE;
				end
				ST_PAGE_CHK: begin
					sel_q <= 1'b0;
					if (pe_q.valid && pe_q.known && pg_q != 64'd0)
						state_q <= ST_DSTART;
					else
						state_q <= ST_FILE_CHK;
				end
				ST_FILE_CHK: begin
					sel_q <= 1'b1;
					if (fe_q.valid && fe_q.known && fg_q != 64'd0)
						state_q <= ST_DSTART;
					else
						state_q <= ST_WRITE;
				end
				ST_DSTART: begin
					small_q <= gap < {24'd0, hl};
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					if (div_done) begin
						if (small_q)
							factor_q <= pad_pkg::FACTOR_ONE - 10'(div_quot >> 1);
						else if (div_quot > 64'(MAX_HALF_LIVES))
							factor_q <= 10'd0;
						else
							factor_q <= pad_pkg::FACTOR_ONE >> div_quot[4:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= {10'd0, old} * {32'd0, factor_q};
					state_q <= ST_RCP_LO;
				end
				ST_RCP_LO: begin
					part_lo_q <= part_lo;
					state_q   <= ST_RCP_HI;
				end
				ST_RCP_HI: begin
					if (sel_q)
						hot_q <= score_new;
					else
						freq_q <= score_new;
					state_q <= sel_q ? ST_WRITE : ST_FILE_CHK;
				end
				ST_WRITE: begin
					result_q <= result_d;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/page_access_decay_tracker.sv =====
// Top level of the page access decay tracker: half-life register, front and back.
// Depends on pad_pkg, pad_front and pad_back.
//
//  channel   handshake                  payload
//  event     start / busy               operation .. time_now
//  result    result_valid (strobe)      record_kind .. file_score
//  config    cfg_valid / cfg_ready      cfg_data (half-life, ns)
//
// An insertion or eviction passes the back end through read, calc and write. An access
// also runs the page and file checks, and for each score that decays a pass of the
// serial divider by the half-life (ratio or half-life count), then a multiply and a
// reciprocal divide by 1000 in two halves. Two events queue in front. After reset a
// clearing pass over max(PAGE_SLOTS, FILE_SLOTS) slots holds busy high. Results show
// for one cycle; the receiver cannot stall them.

module page_access_decay_tracker #(
	parameter int PAGE_SLOTS     = pad_pkg::PAGE_SLOTS_DEF,
	parameter int FILE_SLOTS     = pad_pkg::FILE_SLOTS_DEF,
	parameter int MAX_HALF_LIVES = pad_pkg::MAX_HALF_LIVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [9:0]  page_slot,
	input  logic [7:0]  file_slot,
	input  logic [31:0] device_id,
	input  logic [63:0] inode_number,
	input  logic [63:0] page_index,
	input  logic [63:0] size_of_file,
	input  logic [63:0] time_now,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [39:0] cfg_data,
	output logic        result_valid,
	output logic        record_kind,
	output logic [63:0] page_gap,
	output logic [63:0] page_gap_two,
	output logic [63:0] file_gap,
	output logic [63:0] file_gap_two,
	output logic [11:0] major_number,
	output logic [19:0] minor_number,
	output logic [63:0] inode_out,
	output logic [63:0] index_out,
	output logic [31:0] index_distance,
	output logic [31:0] page_score,
	output logic [31:0] file_score
);

	logic             [39:0] half_life_q;
	logic             head_valid, pop, clearing;
	pad_pkg::cmd_t    head;
	pad_pkg::result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			half_life_q <= pad_pkg::HALF_LIFE_RESET;
		else if (cfg_valid && cfg_ready)
			half_life_q <= cfg_data;
	end

	// The file size input is not used by the block.
	pad_front #(.PAGE_SLOTS(PAGE_SLOTS), .FILE_SLOTS(FILE_SLOTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.hold         (clearing),
		.operation    (operation),
		.page_slot    (page_slot),
		.file_slot    (file_slot),
		.device_id    (device_id),
		.inode_number (inode_number),
		.page_index   (page_index),
		.time_now     (time_now),
		.pop          (pop),
		.busy         (busy),
		.head_valid   (head_valid),
		.head         (head)
	);

	pad_back #(
		.PAGE_SLOTS     (PAGE_SLOTS),
		.FILE_SLOTS     (FILE_SLOTS),
		.MAX_HALF_LIVES (MAX_HALF_LIVES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.half_life    (half_life_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result       (res)
	);

	assign record_kind    = res.kind;
	assign page_gap       = res.page_gap;
	assign page_gap_two   = res.page_gap_two;
	assign file_gap       = res.file_gap;
	assign file_gap_two   = res.file_gap_two;
	assign major_number   = res.major;
	assign minor_number   = res.minor;
	assign inode_out      = res.inode;
	assign index_out      = res.index;
	assign index_distance = res.seq;
	assign page_score     = res.page_score;
	assign file_score     = res.file_score;

endmodule

// ===== rtl/pad_checker.sv =====
// Port-level checks for the page access decay tracker, bound to the top level.
// Depends on pad_pkg and page_access_decay_tracker.

module pad_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        record_kind,
	input logic [63:0] inode_out,
	input logic [11:0] major_number,
	input logic [19:0] minor_number,
	input logic [31:0] index_distance,
	input logic [31:0] page_score,
	input logic [31:0] file_score
);

	// Every event goes through a multi-cycle sequence, so strobes never touch.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("two result transfers in adjacent cycles");

	a_inode_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inode_out != 64'd0)
		else $error("result from an event with zero inode");

	a_device_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (major_number != 12'd0 || minor_number != 20'd0))
		else $error("result from an event with zero device");

	a_insert_short: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && record_kind == pad_pkg::KIND_INSERT
			|-> (index_distance == 32'd0 && page_score == 32'd0 && file_score == 32'd0))
		else $error("insertion record carries scores or distance");

endmodule

bind page_access_decay_tracker pad_checker u_pad_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for page_access_decay_tracker: page and file table tracking with decay.
// Depends on pad_pkg and the RTL of the block. An in-bench tracker model predicts every record.
`timescale 1ns / 1ps

class tracker_scoreboard;
	logic [39:0] half_life;
	bit          pg_valid [1024];
	logic [63:0] pg_prev_time [1024];
	logic [63:0] pg_last_time [1024];
	logic [63:0] pg_last_gap [1024];
	logic [31:0] pg_freq [1024];
	bit          fl_valid [256];
	logic [63:0] fl_recent_index [256];
	logic [63:0] fl_prev_time [256];
	logic [63:0] fl_last_time [256];
	logic [63:0] fl_last_gap [256];
	logic [31:0] fl_hot [256];
	pad_pkg::result_t pending_records [$];
	int mismatches;

	function new();
		half_life = pad_pkg::HALF_LIFE_RESET;
		mismatches = 0;
		for (int i = 0; i < 1024; i++) clear_page(i);
		for (int i = 0; i < 256; i++) begin
			fl_valid[i] = 0;
			fl_recent_index[i] = '0;
			fl_prev_time[i] = '0;
			fl_last_time[i] = '0;
			fl_last_gap[i] = pad_pkg::GAP_UNKNOWN;
			fl_hot[i] = '0;
		end
	endfunction

	function void clear_page(int s);
		pg_valid[s] = 0;
		pg_prev_time[s] = '0;
		pg_last_time[s] = '0;
		pg_last_gap[s] = pad_pkg::GAP_UNKNOWN;
		pg_freq[s] = '0;
	endfunction

	function logic [63:0] elapsed(logic [63:0] now, logic [63:0] then);
		return (now >= then) ? now - then : pad_pkg::GAP_UNKNOWN;
	endfunction

	function logic [31:0] decayed(logic [31:0] old, logic [63:0] gap);
		logic [63:0] hl;
		logic [63:0] factor;
		logic [63:0] halvings;
		logic [63:0] prod;
		hl = (half_life == 0) ? 64'd1 : {24'b0, half_life};
		if (gap < hl) begin
			factor = 64'd1000 - ((gap * 64'd1000) / hl) / 2;
		end else begin
			halvings = gap / hl;
			factor = (halvings > 10) ? 64'd0 : (64'd1000 >> halvings);
		end
		prod = {32'b0, old} * factor;
		return 32'(prod / 64'd1000 + 64'd1000);
	endfunction

	// Called for every accepted transfer on the event channel.
	function void note_event(pad_pkg::op_t op, logic [9:0] ps, logic [7:0] fs,
			logic [31:0] dev, logic [63:0] ino, logic [63:0] idx, logic [63:0] now);
		pad_pkg::result_t r;
		logic [63:0] diff;
		if (dev == 0 || ino == 0 || op == pad_pkg::OP_NONE) return;
		if (op == pad_pkg::OP_EVICT) begin
			clear_page(ps);
			return;
		end
		r = '0;
		r.major = dev[31:20];
		r.minor = dev[19:0];
		r.inode = ino;
		r.index = idx;
		if (op == pad_pkg::OP_ACCESS) begin
			r.kind = pad_pkg::KIND_ACCESS;
			r.page_gap = pad_pkg::GAP_UNKNOWN;
			r.page_gap_two = pad_pkg::GAP_UNKNOWN;
			r.file_gap = pad_pkg::GAP_UNKNOWN;
			r.file_gap_two = pad_pkg::GAP_UNKNOWN;
			r.seq = pad_pkg::DIST_UNKNOWN;
			r.page_score = 32'd1000;
			r.file_score = 32'd1000;
			if (pg_valid[ps]) begin
				r.page_gap = elapsed(now, pg_last_time[ps]);
				if (pg_prev_time[ps] != 0) r.page_gap_two = elapsed(now, pg_prev_time[ps]);
				if (pg_last_gap[ps] != pad_pkg::GAP_UNKNOWN)
					r.page_score = (r.page_gap > 0) ? decayed(pg_freq[ps], r.page_gap)
						: pg_freq[ps] + 32'd1000;
			end
			if (fl_valid[fs]) begin
				diff = (idx > fl_recent_index[fs]) ? idx - fl_recent_index[fs]
					: fl_recent_index[fs] - idx;
				r.file_gap = elapsed(now, fl_last_time[fs]);
				if (fl_prev_time[fs] != 0) r.file_gap_two = elapsed(now, fl_prev_time[fs]);
				r.seq = (diff > 64'hffff_ffff) ? pad_pkg::DIST_UNKNOWN : diff[31:0];
				if (fl_last_gap[fs] == pad_pkg::GAP_UNKNOWN) r.file_score = fl_hot[fs];
				else if (r.file_gap == 0) r.file_score = fl_hot[fs] + 32'd1000;
				else r.file_score = decayed(fl_hot[fs], r.file_gap);
			end
			if (pg_valid[ps]) begin
				pg_prev_time[ps] = pg_last_time[ps];
				pg_last_gap[ps] = r.page_gap;
			end else begin
				pg_prev_time[ps] = '0;
				pg_last_gap[ps] = pad_pkg::GAP_UNKNOWN;
			end
			pg_last_time[ps] = now;
			pg_freq[ps] = r.page_score;
			pg_valid[ps] = 1;
			if (fl_valid[fs]) begin
				fl_prev_time[fs] = fl_last_time[fs];
				fl_last_gap[fs] = r.file_gap;
			end else begin
				fl_prev_time[fs] = '0;
				fl_last_gap[fs] = pad_pkg::GAP_UNKNOWN;
			end
			fl_recent_index[fs] = idx;
			fl_last_time[fs] = now;
			fl_hot[fs] = r.file_score;
			fl_valid[fs] = 1;
		end else begin
			r.kind = pad_pkg::KIND_INSERT;
			if (pg_valid[ps]) begin
				pg_prev_time[ps] = pg_last_time[ps];
			end else begin
				pg_prev_time[ps] = '0;
				pg_freq[ps] = '0;
				pg_last_gap[ps] = pad_pkg::GAP_UNKNOWN;
			end
			pg_last_time[ps] = now;
			pg_valid[ps] = 1;
			if (fl_valid[fs]) begin
				fl_prev_time[fs] = fl_last_time[fs];
			end else begin
				fl_prev_time[fs] = '0;
				fl_last_gap[fs] = pad_pkg::GAP_UNKNOWN;
				fl_hot[fs] = '0;
			end
			fl_recent_index[fs] = idx;
			fl_last_time[fs] = now;
			fl_valid[fs] = 1;
		end
		pending_records.push_back(r);
	endfunction

	function void check_record(pad_pkg::result_t got);
		pad_pkg::result_t want;
		if (pending_records.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected record %h", got);
			return;
		end
		want = pending_records.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) $display("record mismatch\n  exp %h\n  act %h", want, got);
		end
	endfunction
endclass

module tb_top;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [9:0]  page_slot;
	logic [7:0]  file_slot;
	logic [31:0] device_id;
	logic [63:0] inode_number;
	logic [63:0] page_index;
	logic [63:0] size_of_file;
	logic [63:0] time_now;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [39:0] cfg_data;
	logic        result_valid;
	logic        record_kind;
	logic [63:0] page_gap, page_gap_two, file_gap, file_gap_two;
	logic [11:0] major_number;
	logic [19:0] minor_number;
	logic [63:0] inode_out, index_out;
	logic [31:0] index_distance, page_score, file_score;

	tracker_scoreboard sb;
	logic [63:0] stamp;
	bit          no_idle;

	page_access_decay_tracker DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .page_slot(page_slot), .file_slot(file_slot),
		.device_id(device_id), .inode_number(inode_number), .page_index(page_index),
		.size_of_file(size_of_file), .time_now(time_now),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .record_kind(record_kind),
		.page_gap(page_gap), .page_gap_two(page_gap_two),
		.file_gap(file_gap), .file_gap_two(file_gap_two),
		.major_number(major_number), .minor_number(minor_number),
		.inode_out(inode_out), .index_out(index_out), .index_distance(index_distance),
		.page_score(page_score), .file_score(file_score)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_record({record_kind, page_gap, page_gap_two, file_gap, file_gap_two,
				major_number, minor_number, inode_out, index_out, index_distance,
				page_score, file_score});
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Entered just after a falling edge; returns just after a falling edge.
	task automatic send_event(pad_pkg::op_t op, logic [9:0] ps, logic [7:0] fs,
			logic [31:0] dev, logic [63:0] ino, logic [63:0] idx, logic [63:0] fsize,
			logic [63:0] now);
		operation = op;
		page_slot = ps;
		file_slot = fs;
		device_id = dev;
		inode_number = ino;
		page_index = idx;
		size_of_file = fsize;
		time_now = now;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note_event(op, ps, fs, dev, ino, idx, now);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < 36) begin
			start = 0;
			@(negedge clk);
		end
	endtask

	// Hold off until every record is in, then cover events that leave no record.
	task automatic drain();
		start = 0;
		while (sb.pending_records.size() != 0) @(posedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_half_life(logic [39:0] value);
		drain();
		cfg_data = value;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		sb.half_life = value;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic advance_stamp();
		int pick;
		logic [63:0] hl;
		hl = (sb.half_life == 0) ? 64'd1 : {24'b0, sb.half_life};
		pick = $urandom_range(0, 99);
		if (pick < 10) ;
		else if (pick < 18) stamp = stamp - (rand64() % (hl * 3 + 1));
		else if (pick < 21) stamp = rand64();
		else stamp = stamp + (rand64() % (hl * 12 + 1));
	endtask

	task automatic random_event();
		int pick;
		pad_pkg::op_t op;
		logic [9:0] ps;
		logic [7:0] fs;
		logic [31:0] dev;
		logic [63:0] ino, idx;
		pick = $urandom_range(0, 99);
		op = (pick < 55) ? pad_pkg::OP_ACCESS : (pick < 80) ? pad_pkg::OP_INSERT
			: (pick < 94) ? pad_pkg::OP_EVICT : pad_pkg::OP_NONE;
		ps = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 11));
		fs = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
		dev = ($urandom_range(0, 24) == 0) ? 32'd0 : $urandom;
		ino = ($urandom_range(0, 24) == 0) ? 64'd0 : rand64();
		// Mostly near-sequential indices so the distance is often in range.
		idx = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 300));
		advance_stamp();
		send_event(op, ps, fs, dev, ino, idx, rand64(), stamp);
	endtask

	initial begin
		logic [39:0] hl_list [5];
		sb = new();
		arst_n = 0;
		start = 0;
		operation = pad_pkg::OP_ACCESS;
		page_slot = '0;
		file_slot = '0;
		device_id = '0;
		inode_number = '0;
		page_index = '0;
		size_of_file = '0;
		time_now = '0;
		cfg_valid = 0;
		cfg_data = '0;
		no_idle = 0;
		stamp = 64'd5000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed events at the reset half-life.
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd10, 64'd4096,
			64'd1000);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd12, 64'd4096,
			64'd2000);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd11, 64'd4096,
			64'd500000000);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd11, 64'd4096,
			64'd500000000);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0,
			64'd2600000000);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0,
			64'd20000000000);
		// Time going backwards.
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0, 64'd100);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0, 64'd300);
		send_event(pad_pkg::OP_INSERT, 10'd2, 8'd2, 32'hffff_ffff, '1, '1, '1, 64'd400);
		send_event(pad_pkg::OP_INSERT, 10'd2, 8'd2, 32'hffff_ffff, '1, 64'd0, '1, 64'd900);
		send_event(pad_pkg::OP_ACCESS, 10'd2, 8'd2, 32'hffff_ffff, '1, '1, '1, '1);
		send_event(pad_pkg::OP_EVICT, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0, 64'd400);
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'h0010_0001, 64'd7, 64'd9, 64'd0, 64'd500);
		// Ignored events: zero device, zero inode, unknown operation.
		send_event(pad_pkg::OP_ACCESS, 10'd1, 8'd1, 32'd0, 64'd7, 64'd9, 64'd0, 64'd600);
		send_event(pad_pkg::OP_EVICT, 10'd1, 8'd1, 32'd5, 64'd0, 64'd9, 64'd0, 64'd600);
		send_event(pad_pkg::OP_NONE, 10'd1, 8'd1, 32'd5, 64'd7, 64'd9, 64'd0, 64'd600);
		send_event(pad_pkg::OP_ACCESS, 10'd1023, 8'd255, 32'h0000_0001, 64'd1, 64'd0, 64'd0,
			64'd0);
		send_event(pad_pkg::OP_ACCESS, 10'd1023, 8'd255, 32'h0000_0001, 64'd1, 64'h1_0000_0000,
			64'd0, 64'd0);
		send_event(pad_pkg::OP_ACCESS, 10'd1023, 8'd255, 32'h0000_0001, 64'd1, '1, 64'd0,
			64'd70);

		hl_list[0] = 40'd1;
		hl_list[1] = 40'hff_ffff_ffff;
		hl_list[2] = 40'd0;
		hl_list[3] = 40'd5000;
		hl_list[4] = 40'($urandom_range(1000, 100000000));
		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) write_half_life(hl_list[ph - 1]);
			for (int i = 0; i < 140; i++) begin
				// A stretch in the middle of each phase runs without any idle cycle.
				no_idle = (ph == 2 && i >= 20 && i < 130) || (i >= 60 && i < 75);
				if (ph == 3 && i == 70) drain();
				random_event();
			end
			no_idle = 0;
		end

		drain();
		if (sb.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
